FILE: rtl/core/lru_stack_replacement_tracker_unit_assert.svh
// assertion macros used by the lru tracker top level
`ifndef LRU_STACK_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH
`define LRU_STACK_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LRUST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrust assertion failed");

// next-cycle implication, checked out of reset
`define LRUST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrust assertion failed");

`endif

FILE: rtl/core/lrust_pkg.sv
// shared types and constants of the lru tracker
package lrust_pkg;

    // width of a buffer slot index on the channels
    localparam int BID_W = 4;

    typedef enum logic {
        ACT_TOUCH  = 1'b0,
        ACT_REMOVE = 1'b1
    } lrust_act_t;

    typedef struct packed {
        lrust_act_t        action;
        logic [BID_W-1:0]  buffer_id;
    } lrust_req_t;

    typedef struct packed {
        logic [BID_W-1:0]  victim_id;
        logic              victim_valid;
        logic [BID_W-1:0]  recent_id;
        logic              recent_valid;
    } lrust_rsp_t;

endpackage

FILE: rtl/core/lrust_stream_if.sv
// valid/ready channel carrying one payload beat
interface lrust_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lrust_list.sv
// doubly linked recency list: link registers and combinational link update
module lrust_list #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  lrust_pkg::lrust_req_t item,
    output lrust_pkg::lrust_rsp_t status
);
    import lrust_pkg::*;

    localparam int MAX_IDS = 1 << BID_W;
    localparam int DEPTH   = (NUM_SLOTS < MAX_IDS) ? NUM_SLOTS : MAX_IDS;
    localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_SLOTS);
    localparam logic [BID_W:0]    ID_LIMIT  = (BID_W+1)'(DEPTH);

    logic [LINK_W-1:0] next_reg [DEPTH];
    logic [LINK_W-1:0] next_next [DEPTH];
    logic [LINK_W-1:0] prev_reg [DEPTH];
    logic [LINK_W-1:0] prev_next [DEPTH];
    logic [DEPTH-1:0]  on_reg;
    logic [DEPTH-1:0]  on_next;
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] tail_reg;
    logic [LINK_W-1:0] tail_next;

    logic              id_ok;
    logic [IDX_W-1:0]  slot;
    logic [LINK_W-1:0] slot_link;
    logic              present;
    logic              is_head;
    logic [LINK_W-1:0] p_link;
    logic [LINK_W-1:0] n_link;
    logic              p_null;
    logic              n_null;
    logic              do_unlink;
    logic              do_push;
    logic [LINK_W-1:0] head_mid;
    logic [LINK_W-1:0] tail_mid;
    logic              head_mid_null;

    assign id_ok     = {1'b0, item.buffer_id} < ID_LIMIT;
    assign slot      = item.buffer_id[IDX_W-1:0];
    assign slot_link = LINK_W'(slot);
    assign present   = on_reg[slot];
    assign is_head   = present && (head_reg == slot_link);
    assign p_link    = prev_reg[slot];
    assign n_link    = next_reg[slot];
    assign p_null    = (p_link == LINK_NULL);
    assign n_null    = (n_link == LINK_NULL);

    // a touch of a listed slot other than the head unlinks before pushing
    assign do_unlink = step && id_ok && present
                       && ((item.action == ACT_REMOVE) || !is_head);
    assign do_push   = step && id_ok && (item.action == ACT_TOUCH) && !is_head;

    // list ends after the unlink half
    assign head_mid      = (do_unlink && p_null) ? n_link : head_reg;
    assign tail_mid      = (do_unlink && n_null) ? p_link : tail_reg;
    assign head_mid_null = (head_mid == LINK_NULL);

    assign head_next = do_push ? slot_link : head_mid;
    assign tail_next = (do_push && head_mid_null) ? slot_link : tail_mid;

    // per-entry link writes, push wins over unlink
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            next_next[i] = next_reg[i];
            prev_next[i] = prev_reg[i];
            on_next[i]   = on_reg[i];
            if (do_unlink && !p_null && (p_link == LINK_W'(i)))
            begin
                next_next[i] = n_link;
            end
            if (do_unlink && !n_null && (n_link == LINK_W'(i)))
            begin
                prev_next[i] = p_link;
            end
            if (do_unlink && (slot_link == LINK_W'(i)))
            begin
                next_next[i] = LINK_NULL;
                prev_next[i] = LINK_NULL;
                on_next[i]   = 1'b0;
            end
            if (do_push && !head_mid_null && (head_mid == LINK_W'(i)))
            begin
                prev_next[i] = slot_link;
            end
            if (do_push && (slot_link == LINK_W'(i)))
            begin
                next_next[i] = head_mid;
                prev_next[i] = LINK_NULL;
                on_next[i]   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                next_reg[i] <= LINK_NULL;
                prev_reg[i] <= LINK_NULL;
            end
            on_reg   <= '0;
            head_reg <= LINK_NULL;
            tail_reg <= LINK_NULL;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                next_reg[i] <= next_next[i];
                prev_reg[i] <= prev_next[i];
            end
            on_reg   <= on_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_comb
    begin
        if ((head_next != LINK_NULL) && (tail_next != LINK_NULL))
        begin
            status.victim_id    = BID_W'(tail_next);
            status.victim_valid = 1'b1;
            status.recent_id    = BID_W'(head_next);
            status.recent_valid = 1'b1;
        end
        else
        begin
            status = '0;
        end
    end

endmodule

FILE: rtl/core/lru_stack_replacement_tracker_unit.sv
// lru replacement tracker: top level with input and result registers
//
// usage
//   req carries one beat per access: action (touch or remove) and buffer_id
//   rsp carries one beat per accepted req beat: victim_id/victim_valid
//   (least recent slot) and recent_id/recent_valid (most recent slot),
//   both reported after the access took effect; ids read 0 when empty
//   ids at or above NUM_SLOTS leave the list alone and still get a beat
// timing
//   one req beat per cycle sustained while rsp is not stalled; an accepted
//   beat is held in the input register, runs through the list update and
//   lands in the result register, from which the rsp beat is offered
// reset
//   rst_n clears the list to empty and drops both pipeline valids
// backpressure
//   a stalled rsp holds the result register; the input register drains
//   into it as soon as it frees, so req.ready only drops while both the
//   input register and the result register are full and rsp is stalled
`include "lru_stack_replacement_tracker_unit_assert.svh"

module lru_stack_replacement_tracker_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    lrust_stream_if.sink        req,
    lrust_stream_if.source      rsp
);
    import lrust_pkg::*;

    localparam int MAX_IDS = 1 << BID_W;
    localparam int DEPTH   = (NUM_SLOTS < MAX_IDS) ? NUM_SLOTS : MAX_IDS;
    localparam logic [BID_W:0] ID_LIMIT = (BID_W+1)'(DEPTH);

    // input register
    logic       item_valid_reg;
    logic       item_valid_next;
    lrust_req_t item_reg;
    lrust_req_t item_next;

    // result register
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    lrust_rsp_t rsp_reg;
    lrust_rsp_t rsp_next;

    logic       advance;
    logic       step;
    logic       req_fire;
    lrust_rsp_t status;

    // result register free or emptying this cycle
    assign advance  = !rsp_valid_reg || rsp.ready;
    // the held item goes through the list update
    assign step     = item_valid_reg && advance;
    assign req.ready = !item_valid_reg || advance;
    assign req_fire = req.valid && req.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    lrust_list #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .status (status)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (req_fire)
        begin
            item_valid_next = 1'b1;
            item_next       = req.data;
        end
        else if (step)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (step)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = status;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    // an accepted beat is always held in the input register next cycle
    `LRUST_ASSERT_NEXT(a_req_captured, clk, rst_n, req_fire, item_valid_reg)
    // a held item that cannot advance stays put
    `LRUST_ASSERT_NEXT(a_item_holds, clk, rst_n, item_valid_reg && !advance,
                       item_valid_reg && $stable(item_reg))
    // a touch of an in-range slot leaves a non-empty list with it on top
    `LRUST_ASSERT_NEXT(a_touch_on_top, clk, rst_n,
                       step && (item_reg.action == ACT_TOUCH)
                       && ({1'b0, item_reg.buffer_id} < ID_LIMIT),
                       rsp_valid_reg && rsp_reg.recent_valid && rsp_reg.victim_valid
                       && (rsp_reg.recent_id == $past(item_reg.buffer_id)))

endmodule

FILE: test/lru_stack_replacement_tracker_unit_tb.sv
// testbench for the lru replacement tracker: directed table, random phases, lru order predictor
module lru_stack_replacement_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrust_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [4:0] LINK_NONE = 5'(SLOTS);
    // no-accept cycles tolerated: long hold plus a few stall bursts, taken many times over
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_SHOWN = 10;

    logic clk;
    logic rst_n;

    lrust_stream_if #(.data_t(lrust_req_t)) req_if ();
    lrust_stream_if #(.data_t(lrust_rsp_t)) rsp_if ();

    lru_stack_replacement_tracker_unit #(
        .NUM_SLOTS(SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // lru order predictor: doubly linked list, head = most recent
    // ------------------------------------------------------------------
    logic [4:0] order_next [SLOTS];
    logic [4:0] order_prev [SLOTS];
    bit         on_order   [SLOTS];
    logic [4:0] mru_slot;
    logic [4:0] lru_slot;

    // pull a slot out of the list, patching its neighbors or the ends
    function automatic void detach_slot(input int s);
        logic [4:0] p;
        logic [4:0] n;
        p = order_prev[s];
        n = order_next[s];
        if (p >= LINK_NONE)
            mru_slot = n;
        else
            order_next[p] = n;
        if (n >= LINK_NONE)
            lru_slot = p;
        else
            order_prev[n] = p;
        order_next[s] = LINK_NONE;
        order_prev[s] = LINK_NONE;
        on_order[s] = 1'b0;
    endfunction

    // link a slot in front of the current head
    function automatic void push_mru(input int s);
        order_prev[s] = LINK_NONE;
        order_next[s] = mru_slot;
        if (mru_slot >= LINK_NONE)
            lru_slot = 5'(s);
        else
            order_prev[mru_slot] = 5'(s);
        mru_slot = 5'(s);
        on_order[s] = 1'b1;
    endfunction

    // apply one access and return the victim/recent report it produces
    function automatic lrust_rsp_t lru_track(input lrust_req_t beat);
        int s;
        lrust_rsp_t rep;
        s = int'(beat.buffer_id);
        if (s < SLOTS) begin
            if (beat.action == ACT_REMOVE) begin
                if (on_order[s])
                    detach_slot(s);
            end
            else if (!(on_order[s] && mru_slot == 5'(s))) begin
                // touch of the head changes nothing, anything else moves to the head
                if (on_order[s])
                    detach_slot(s);
                push_mru(s);
            end
        end
        rep = '0;
        if (mru_slot < LINK_NONE && lru_slot < LINK_NONE) begin
            rep.victim_id    = lru_slot[3:0];
            rep.victim_valid = 1'b1;
            rep.recent_id    = mru_slot[3:0];
            rep.recent_valid = 1'b1;
        end
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // directed table: typed reports only where obvious, else predictor
    // ------------------------------------------------------------------
    typedef struct {
        lrust_act_t act;
        logic [3:0] id;
        bit         typed;
        logic [3:0] want_vid;
        logic       want_vval;
        logic [3:0] want_rid;
        logic       want_rval;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ACT_REMOVE, 4'd3,  1'b1, 4'd0,  1'b0, 4'd0,  1'b0},  // remove on empty list
        '{ACT_TOUCH,  4'd0,  1'b1, 4'd0,  1'b1, 4'd0,  1'b1},  // first entry
        '{ACT_TOUCH,  4'd0,  1'b1, 4'd0,  1'b1, 4'd0,  1'b1},  // touch of the head
        '{ACT_REMOVE, 4'd0,  1'b1, 4'd0,  1'b0, 4'd0,  1'b0},  // remove the only entry
        '{ACT_REMOVE, 4'd0,  1'b1, 4'd0,  1'b0, 4'd0,  1'b0},  // remove an absent slot
        '{ACT_TOUCH,  4'd15, 1'b1, 4'd15, 1'b1, 4'd15, 1'b1},  // top slot index
        '{ACT_TOUCH,  4'd0,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},
        '{ACT_TOUCH,  4'd5,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},
        '{ACT_TOUCH,  4'd10, 1'b0, 4'd0,  1'b0, 4'd0,  1'b0},
        '{ACT_TOUCH,  4'd15, 1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // move tail to head
        '{ACT_TOUCH,  4'd5,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // move middle to head
        '{ACT_TOUCH,  4'd5,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // head again
        '{ACT_REMOVE, 4'd7,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // absent, list not empty
        '{ACT_REMOVE, 4'd0,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // remove the tail
        '{ACT_REMOVE, 4'd5,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // remove the head
        '{ACT_TOUCH,  4'd9,  1'b0, 4'd0,  1'b0, 4'd0,  1'b0},
        '{ACT_REMOVE, 4'd15, 1'b0, 4'd0,  1'b0, 4'd0,  1'b0},  // remove from the middle
        '{ACT_REMOVE, 4'd10, 1'b0, 4'd0,  1'b0, 4'd0,  1'b0},
        '{ACT_REMOVE, 4'd9,  1'b1, 4'd0,  1'b0, 4'd0,  1'b0},  // list drains to empty
        '{ACT_TOUCH,  4'd10, 1'b1, 4'd10, 1'b1, 4'd10, 1'b1}
    };

    // ------------------------------------------------------------------
    // shared run state
    // ------------------------------------------------------------------
    lrust_rsp_t pending_reports [$];
    int  fail_count;
    int  idle_pct;      // chance in percent that either side starts an idle burst
    bit  quiet;         // tail of the run: no idling at all
    bit  hold_due;      // ask the receiver for one long hold-off
    bit  hold_active;

    // ------------------------------------------------------------------
    // request side: reset, directed table, random phases, drain
    // ------------------------------------------------------------------
    // offer one beat and wait for the edge that takes it
    task automatic offer_beat(input lrust_req_t beat);
        int gap;
        if (!quiet && !hold_active && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 17);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    initial begin : stimulus
        lrust_req_t beat;
        lrust_rsp_t want;
        int id_max;
        int rm_pct;
        int pick;
        int n_items;

        rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        fail_count = 0;
        idle_pct = 0;
        quiet = 1'b0;
        hold_due = 1'b0;
        hold_active = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            order_next[i] = LINK_NONE;
            order_prev[i] = LINK_NONE;
            on_order[i] = 1'b0;
        end
        mru_slot = LINK_NONE;
        lru_slot = LINK_NONE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, light idling on both sides
        idle_pct = 15;
        for (int r = 0; r < DIR_ROWS; r++) begin
            beat.action    = dir_rows[r].act;
            beat.buffer_id = dir_rows[r].id;
            offer_beat(beat);
            want = lru_track(beat);
            if (dir_rows[r].typed) begin
                want.victim_id    = dir_rows[r].want_vid;
                want.victim_valid = dir_rows[r].want_vval;
                want.recent_id    = dir_rows[r].want_rid;
                want.recent_valid = dir_rows[r].want_rval;
            end
            pending_reports.push_back(want);
        end

        // random phases: hot set with heavy idling, full range with the long hold,
        // mid range with heavy idling, full range with no idling at all
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin id_max = 3;  rm_pct = 30; idle_pct = 25; n_items = 170; end
                1: begin id_max = 15; rm_pct = 25; idle_pct = 0;  n_items = 180; end
                2: begin id_max = 7;  rm_pct = 40; idle_pct = 40; n_items = 170; end
                default: begin
                    id_max = 15; rm_pct = 35; idle_pct = 0; n_items = 170; quiet = 1'b1;
                end
            endcase
            if (ph == 1)
                hold_due = 1'b1;
            for (int k = 0; k < n_items; k++) begin
                pick = $urandom_range(0, 99);
                // aim some accesses at the current ends of the list
                if (pick < 8 && mru_slot < LINK_NONE)
                    beat.buffer_id = mru_slot[3:0];
                else if (pick < 16 && lru_slot < LINK_NONE)
                    beat.buffer_id = lru_slot[3:0];
                else
                    beat.buffer_id = 4'($urandom_range(0, id_max));
                beat.action = ($urandom_range(0, 99) < rm_pct) ? ACT_REMOVE : ACT_TOUCH;
                offer_beat(beat);
                pending_reports.push_back(lru_track(beat));
            end
        end
        req_if.valid <= 1'b0;

        // wait for every report, then a few cycles to catch stray beats
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: ready bursts plus one long hold-off to fill the pipe
    // ------------------------------------------------------------------
    initial begin : rsp_ready_drive
        int stall_left;
        int held;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_due && !quiet) begin
                // long hold counted here while the sender keeps offering
                hold_due = 1'b0;
                hold_active = 1'b1;
                rsp_if.ready <= 1'b0;
                for (held = 1; held < LONG_HOLD; held++)
                    @(posedge clk);
                hold_active = 1'b0;
                stall_left = 0;
            end
            else if (quiet) begin
                rsp_if.ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < idle_pct) begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // report checker: every rsp beat against the oldest expectation
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input lrust_rsp_t want,
                                 input lrust_rsp_t got);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%t %s: want victim %0d/%0b recent %0d/%0b, got victim %0d/%0b recent %0d/%0b",
                     $realtime, what, want.victim_id, want.victim_valid, want.recent_id,
                     want.recent_valid, got.victim_id, got.victim_valid, got.recent_id,
                     got.recent_valid);
    endtask

    always @(posedge clk) begin : report_check
        lrust_rsp_t want;
        lrust_rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_reports.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end
            else begin
                want = pending_reports.pop_front();
                if (got.victim_id !== want.victim_id || got.victim_valid !== want.victim_valid
                    || got.recent_id !== want.recent_id
                    || got.recent_valid !== want.recent_valid)
                    note_mismatch("report mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without a beat on either channel
    // ------------------------------------------------------------------
    always @(posedge clk) begin : stall_watch
        int dead_cycles;
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            dead_cycles = 0;
        end
        else begin
            dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("%t no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
